// ===== hdl/rn_pkg.sv =====
package rn_pkg;

  localparam int WIDTH = 32;
  localparam int MAG_W = WIDTH - 1;
  localparam int CNT_W = $clog2(MAG_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD_TEST,
    ST_GCD_WAIT,
    ST_NUM_WAIT,
    ST_DEN_WAIT,
    ST_OUT
  } rn_state_t;

  typedef enum logic [1:0] {
    DSEL_GCD,
    DSEL_NUM,
    DSEL_DEN
  } rn_dsel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    rn_dsel_t div_sel;
    logic     gcd_step;
    logic     store_qn;
    logic     store_qd;
  } rn_cmd_t;

  typedef struct packed {
    logic y_zero;
    logic div_done;
  } rn_status_t;

endpackage

// ===== hdl/rn_div.sv =====
module rn_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [rn_pkg::MAG_W-1:0] dividend,
  input  logic [rn_pkg::MAG_W-1:0] divisor,
  output logic                    done,
  output logic [rn_pkg::MAG_W-1:0] quotient,
  output logic [rn_pkg::MAG_W-1:0] remainder
);

  logic [rn_pkg::MAG_W-1:0] rem;
  logic [rn_pkg::MAG_W-1:0] quo;
  logic [rn_pkg::MAG_W-1:0] dvs;
  logic [rn_pkg::CNT_W-1:0] cnt;
  logic                     run;
  logic [rn_pkg::MAG_W:0]   trial;
  logic [rn_pkg::MAG_W:0]   diff;
  logic                     fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, quo[rn_pkg::MAG_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == '0);
      if (start) begin
        run <= 1'b1;
      end else if (run && (cnt == '0)) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
      cnt <= rn_pkg::CNT_W'(rn_pkg::MAG_W - 1);
    end else if (run) begin
      rem <= fits ? diff[rn_pkg::MAG_W-1:0] : trial[rn_pkg::MAG_W-1:0];
      quo <= {quo[rn_pkg::MAG_W-2:0], fits};
      cnt <= cnt - 1'b1;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== hdl/rn_datapath.sv =====
module rn_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  rn_pkg::rn_cmd_t          cmd,
  output rn_pkg::rn_status_t       status,
  input  logic signed [rn_pkg::WIDTH-1:0] num_in,
  input  logic signed [rn_pkg::WIDTH-1:0] den_in,
  output logic signed [rn_pkg::WIDTH-1:0] num_out,
  output logic [rn_pkg::MAG_W-1:0] den_out,
  output logic                     den_was_zero
);

  logic [rn_pkg::MAG_W-1:0] x, y, nmag, dmag, qn, qd;
  logic                     nneg, dneg, zflag;
  logic [rn_pkg::WIDTH-1:0] nabs, dabs;
  logic [rn_pkg::MAG_W-1:0] nsat, dsat;
  logic [rn_pkg::MAG_W-1:0] div_a, div_b;
  logic                     div_done;
  logic [rn_pkg::MAG_W-1:0] div_q, div_r;
  logic                     neg;
  logic [rn_pkg::WIDTH-1:0] qn_ext;

  // magnitudes, most negative value saturated
  assign nabs = num_in[rn_pkg::WIDTH-1] ? (~num_in + 1'b1) : num_in;
  assign dabs = den_in[rn_pkg::WIDTH-1] ? (~den_in + 1'b1) : den_in;
  assign nsat = nabs[rn_pkg::WIDTH-1] ? '1 : nabs[rn_pkg::MAG_W-1:0];
  assign dsat = dabs[rn_pkg::WIDTH-1] ? '1 : dabs[rn_pkg::MAG_W-1:0];

  always_comb begin
    unique case (cmd.div_sel)
      rn_pkg::DSEL_GCD: begin
        div_a = x;
        div_b = y;
      end
      rn_pkg::DSEL_NUM: begin
        div_a = nmag;
        div_b = x;
      end
      rn_pkg::DSEL_DEN: begin
        div_a = dmag;
        div_b = x;
      end
      default: begin
        div_a = x;
        div_b = y;
      end
    endcase
  end

  rn_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      nmag  <= nsat;
      nneg  <= num_in[rn_pkg::WIDTH-1];
      x     <= nsat;
      zflag <= (dsat == '0);
      if (dsat == '0) begin
        dmag <= rn_pkg::MAG_W'(1);
        y    <= rn_pkg::MAG_W'(1);
        dneg <= 1'b0;
      end else begin
        dmag <= dsat;
        y    <= dsat;
        dneg <= den_in[rn_pkg::WIDTH-1];
      end
    end else if (cmd.gcd_step) begin
      x <= y;
      y <= div_r;
    end
    if (cmd.store_qn) begin
      qn <= div_q;
    end
    if (cmd.store_qd) begin
      qd <= div_q;
    end
  end

  assign status.y_zero   = (y == '0);
  assign status.div_done = div_done;

  assign neg          = (nneg != dneg) && (qn != '0);
  assign qn_ext       = {1'b0, qn};
  assign num_out      = neg ? (~qn_ext + 1'b1) : qn_ext;
  assign den_out      = qd;
  assign den_was_zero = zflag;

endmodule

// ===== hdl/rn_ctrl.sv =====
module rn_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  rn_pkg::rn_status_t status,
  output rn_pkg::rn_cmd_t    cmd,
  output logic               busy,
  output logic               done
);

  rn_pkg::rn_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = rn_pkg::DSEL_GCD;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      rn_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = rn_pkg::ST_GCD_TEST;
        end
      end
      rn_pkg::ST_GCD_TEST: begin
        cmd.div_start = 1'b1;
        if (status.y_zero) begin
          cmd.div_sel = rn_pkg::DSEL_NUM;
          state_next  = rn_pkg::ST_NUM_WAIT;
        end else begin
          state_next = rn_pkg::ST_GCD_WAIT;
        end
      end
      rn_pkg::ST_GCD_WAIT: begin
        if (status.div_done) begin
          cmd.gcd_step = 1'b1;
          state_next   = rn_pkg::ST_GCD_TEST;
        end
      end
      rn_pkg::ST_NUM_WAIT: begin
        if (status.div_done) begin
          cmd.store_qn  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = rn_pkg::DSEL_DEN;
          state_next    = rn_pkg::ST_DEN_WAIT;
        end
      end
      rn_pkg::ST_DEN_WAIT: begin
        if (status.div_done) begin
          cmd.store_qd = 1'b1;
          state_next   = rn_pkg::ST_OUT;
        end
      end
      rn_pkg::ST_OUT: begin
        done       = 1'b1;
        state_next = rn_pkg::ST_IDLE;
      end
      default: begin
        state_next = rn_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == rn_pkg::ST_GCD_WAIT || state == rn_pkg::ST_NUM_WAIT ||
                         state == rn_pkg::ST_DEN_WAIT))
    else $error("divider finished outside a wait state");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transaction accepted but block not busy");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe longer than one cycle");
  a_store_qd: assert property (@(posedge clk) disable iff (rst)
    cmd.store_qd |=> done)
    else $error("result not presented after last division");
`endif

endmodule

// ===== hdl/rational_normalizer.sv =====
// Reduces a signed fraction num_in/den_in to lowest terms. A transaction is
// taken when start is high and busy is low; the result appears for exactly one
// cycle with done high and must be captured then, as it cannot be held off.
// A zero denominator is treated as one and flags den_was_zero; the sign goes to
// num_out and den_out is always positive. Work is done by one shared
// bit-serial divider (one quotient bit per cycle): each Euclid remainder
// step is one division, then the two final divisions by the gcd give the
// reduced magnitudes, and a last state shows them with done high; busy stays
// high for the whole transaction, and the number of Euclid steps runs from
// 1 up to about 45 for 31-bit values.
module rational_normalizer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [rn_pkg::WIDTH-1:0] num_in,
  input  logic signed [rn_pkg::WIDTH-1:0] den_in,
  output logic                            done,
  output logic signed [rn_pkg::WIDTH-1:0] num_out,
  output logic [rn_pkg::MAG_W-1:0]        den_out,
  output logic                            den_was_zero
);

  rn_pkg::rn_cmd_t    cmd;
  rn_pkg::rn_status_t status;

  rn_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  rn_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .num_in       (num_in),
    .den_in       (den_in),
    .num_out      (num_out),
    .den_out      (den_out),
    .den_was_zero (den_was_zero)
  );

endmodule

// ===== tb/rational_normalizer_tb.sv =====
module rational_normalizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int               WIDTH = rn_pkg::WIDTH;
  localparam int               MAG_W = rn_pkg::MAG_W;
  localparam logic [WIDTH-1:0] MAX_MAG  = {1'b0, {MAG_W{1'b1}}};
  localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {MAG_W{1'b0}}};
  localparam int               DRAIN_CYCLES = 2000;
  localparam int               REPORT_CAP   = 50;

  typedef struct {
    logic signed [WIDTH-1:0] num;
    logic signed [WIDTH-1:0] den;
  } fraction_in_t;

  typedef struct {
    logic signed [WIDTH-1:0] num;
    logic [MAG_W-1:0]        den;
    logic                    den_zero;
  } fraction_out_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [WIDTH-1:0] num_in = '0;
  logic signed [WIDTH-1:0] den_in = '0;
  logic                    done;
  logic signed [WIDTH-1:0] num_out;
  logic [MAG_W-1:0]        den_out;
  logic                    den_was_zero;

  fraction_in_t  pending_fracs[$];
  fraction_out_t expected_fracs[$];
  fraction_in_t  next_frac;
  fraction_out_t want;
  int            idle_pct = 0;
  int            errors = 0;

  rational_normalizer dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .num_in       (num_in),
    .den_in       (den_in),
    .done         (done),
    .num_out      (num_out),
    .den_out      (den_out),
    .den_was_zero (den_was_zero)
  );

  always #10 clk = ~clk;

  // saturated magnitude of a two's-complement word
  function automatic logic [WIDTH-1:0] sat_mag(input logic [WIDTH-1:0] w);
    logic [WIDTH-1:0] m;
    m = w[WIDTH-1] ? -w : w;
    if (m > MAX_MAG) m = MAX_MAG;
    return m;
  endfunction

  function automatic fraction_out_t reduce_fraction(input logic [WIDTH-1:0] n_raw,
                                                    input logic [WIDTH-1:0] d_raw);
    logic             n_neg, d_neg, zero_d;
    logic [WIDTH-1:0] n_mag, d_mag, x, y, r, qn, qd;
    fraction_out_t    f;
    n_neg  = n_raw[WIDTH-1];
    d_neg  = d_raw[WIDTH-1];
    n_mag  = sat_mag(n_raw);
    d_mag  = sat_mag(d_raw);
    zero_d = (d_mag == '0);
    if (zero_d) begin
      d_mag = 1;
      d_neg = 1'b0;
    end
    x = n_mag;
    y = d_mag;
    while (y != '0) begin
      r = x % y;
      x = y;
      y = r;
    end
    qn = n_mag / x;
    qd = d_mag / x;
    f.num      = ((n_neg != d_neg) && (qn != '0)) ? -qn : qn;
    f.den      = qd[MAG_W-1:0];
    f.den_zero = zero_d;
    return f;
  endfunction

  task automatic push_frac(input logic [WIDTH-1:0] n, input logic [WIDTH-1:0] d);
    fraction_in_t t;
    t.num = n;
    t.den = d;
    pending_fracs.push_back(t);
  endtask

  task automatic push_random(input int count);
    int unsigned   a, b, g, sel;
    longint        fa, fb, ft;
    logic [WIDTH-1:0] n, d;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        n = $urandom;
        d = $urandom;
      end else if (sel < 70) begin
        g = $urandom_range(1, (sel < 55) ? 64 : 32768);
        a = $urandom_range(0, 32767);
        b = $urandom_range(0, 32767);
        n = a * g;
        d = b * g;
        if ($urandom_range(1)) n = -n;
        if ($urandom_range(1)) d = -d;
      end else if (sel < 80) begin
        n = $urandom_range(40) - 20;
        d = $urandom_range(40) - 20;
      end else if (sel < 90) begin
        case ($urandom_range(5))
          0: n = '0;
          1: n = MAX_MAG;
          2: n = -MAX_MAG;
          3: n = MOST_NEG;
          default: n = $urandom;
        endcase
        case ($urandom_range(5))
          0: d = '0;
          1: d = 1;
          2: d = -1;
          3: d = MOST_NEG;
          4: d = MAX_MAG;
          default: d = $urandom;
        endcase
      end else begin
        // consecutive Fibonacci terms: longest remainder chain
        fa = 1;
        fb = 1;
        repeat ($urandom_range(2, 44)) begin
          ft = fa + fb;
          fa = fb;
          fb = ft;
        end
        if ($urandom_range(1)) begin
          n = WIDTH'(fb);
          d = WIDTH'(fa);
        end else begin
          n = WIDTH'(fa);
          d = WIDTH'(fb);
        end
        if ($urandom_range(1)) n = -n;
        if ($urandom_range(1)) d = -d;
      end
      push_frac(n, d);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start  <= 1'b0;
      num_in <= '0;
      den_in <= '0;
    end else begin
      if (start && !busy) expected_fracs.push_back(reduce_fraction(num_in, den_in));
      if (!start || !busy) begin
        if (pending_fracs.size() != 0 && $urandom_range(99) >= idle_pct &&
            (idle_pct == 0 || !busy || $urandom_range(1) == 1)) begin
          next_frac = pending_fracs.pop_front();
          start  <= 1'b1;
          num_in <= next_frac.num;
          den_in <= next_frac.den;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_fracs.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: unexpected result num_out %0d den_out %0d den_was_zero %0b",
                   $time, num_out, den_out, den_was_zero);
      end else begin
        want = expected_fracs.pop_front();
        if (num_out !== want.num) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: num_out expected %0d actual %0d", $time, want.num, num_out);
        end
        if (den_out !== want.den) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: den_out expected %0d actual %0d", $time, want.den, den_out);
        end
        if (den_was_zero !== want.den_zero) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: den_was_zero expected %0b actual %0b",
                     $time, want.den_zero, den_was_zero);
        end
      end
    end
  end

  initial begin
    int phase_pct[4];
    phase_pct = '{0, 74, 31, 0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed
    push_frac(0, 0);
    push_frac(0, 5);
    push_frac(0, -5);
    push_frac(0, MOST_NEG);
    push_frac(5, 0);
    push_frac(-5, 0);
    push_frac(MOST_NEG, 0);
    push_frac(MAX_MAG, MAX_MAG);
    push_frac(MAX_MAG, 1);
    push_frac(-MAX_MAG, 1);
    push_frac(1, MAX_MAG);
    push_frac(1, -MAX_MAG);
    push_frac(MOST_NEG, MOST_NEG);
    push_frac(MOST_NEG, 1);
    push_frac(1, MOST_NEG);
    push_frac(6, -4);
    push_frac(-6, -4);
    push_frac(-6, 4);
    push_frac(MAX_MAG, MAX_MAG - 1);
    push_frac(1836311903, 1134903170);
    push_frac(12, 12);
    push_frac(7, 1);
    push_frac(32'h4000_0000, 32'h2000_0000);
    push_frac(-1, -1);

    foreach (phase_pct[p]) begin
      while (pending_fracs.size() != 0 || start || expected_fracs.size() != 0)
        @(posedge clk);
      @(negedge clk);
      idle_pct = phase_pct[p];
      push_random(375);
    end

    while (pending_fracs.size() != 0 || start || expected_fracs.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
